// ===== src/b64sd_pkg.sv =====
// Shared types and helpers for the base64url stream decoder.
// Holds the result item layout, the push bundle and the character lookup.
// No dependencies.
package b64sd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int REPORT_BITS    = 16;

  typedef struct packed {
    logic                   is_status;
    logic [7:0]             data_byte;
    logic                   status_code;
    logic [REPORT_BITS-1:0] byte_count;
    logic                   last_result;
  } b64sd_res_t;

  // Results produced by one input character, in order: r0 then r1.
  typedef struct packed {
    logic [1:0] num;
    b64sd_res_t r0;
    b64sd_res_t r1;
  } b64sd_push_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CORRUPT = 1'b1;

  // Returns {bad, sextet}; bad set when the low seven bits are not in the url-safe alphabet (bit 7 is ignored).
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] c;
    logic [6:0] res;
    c   = ch[6:0];
    res = 7'h40;
    if (c >= 7'h41 && c <= 7'h5a) begin
      res = c - 7'h41;
    end else if (c >= 7'h61 && c <= 7'h7a) begin
      res = c - 7'h61 + 7'd26;
    end else if (c >= 7'h30 && c <= 7'h39) begin
      res = c - 7'h30 + 7'd52;
    end else if (c == 7'h2d) begin
      res = 7'h3e;
    end else if (c == 7'h5f) begin
      res = 7'h3f;
    end
    return res;
  endfunction

  // Tab, LF, VT, FF, CR and space, checked on the raw byte.
  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0d);
  endfunction

endpackage

// ===== src/b64sd_core.sv =====
// Decode state and per-character logic of the base64url stream decoder.
// Produces up to two result items per accepted character.
// Depends on b64sd_pkg.
module b64sd_core #(
  parameter int COUNT_BITS = b64sd_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          in_char,
  input  logic                final_char,
  output b64sd_pkg::b64sd_push_t push
);
  import b64sd_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam int         WIDE_BITS = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;

  logic [1:0]            group_phase_r, group_phase_nxt;
  logic [7:0]            pending_first_r, pending_first_nxt;
  logic [5:0]            prev_sextet_r, prev_sextet_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  corrupt_r, corrupt_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic [1:0]            chars_seen_r, chars_seen_nxt;

  logic [6:0]            cur_sx;
  logic [6:0]            first_sx;
  logic                  have_byte;
  logic [7:0]            dec_byte;
  logic                  bad;
  logic [WIDE_BITS-1:0]  cnt_wide;
  logic [REPORT_BITS-1:0] cnt_rep;
  b64sd_res_t            data_res;
  b64sd_res_t            stat_res;

  assign cur_sx   = sextet_of(in_char);
  assign first_sx = sextet_of(pending_first_r);

  always_comb begin
    group_phase_nxt   = group_phase_r;
    pending_first_nxt = pending_first_r;
    prev_sextet_nxt   = prev_sextet_r;
    stopped_nxt       = stopped_r;
    corrupt_nxt       = corrupt_r;
    out_count_nxt     = out_count_r;
    chars_seen_nxt    = chars_seen_r;
    have_byte         = 1'b0;
    dec_byte          = '0;

    if (take) begin
      if (chars_seen_r != 2'd2) chars_seen_nxt = chars_seen_r + 2'd1;
      if (!stopped_r && !corrupt_r) begin
        if (group_phase_r == PH_FIRST) begin
          if (is_blank(in_char)) begin
            if (!final_char) stopped_nxt = 1'b1;
          end else begin
            pending_first_nxt = in_char;
            group_phase_nxt   = PH_SECOND;
          end
        end else if (is_blank(in_char)) begin
          stopped_nxt = 1'b1;
        end else if (group_phase_r == PH_SECOND) begin
          if (first_sx[6] || cur_sx[6]) begin
            corrupt_nxt = 1'b1;
          end else begin
            dec_byte        = {first_sx[5:0], cur_sx[5:4]};
            have_byte       = 1'b1;
            prev_sextet_nxt = cur_sx[5:0];
            group_phase_nxt = PH_THIRD;
          end
        end else if (cur_sx[6]) begin
          corrupt_nxt = 1'b1;
        end else if (group_phase_r == PH_THIRD) begin
          dec_byte        = {prev_sextet_r[3:0], cur_sx[5:2]};
          have_byte       = 1'b1;
          prev_sextet_nxt = cur_sx[5:0];
          group_phase_nxt = group_phase_r + 2'd1;
        end else begin
          dec_byte        = {prev_sextet_r[1:0], cur_sx[5:0]};
          have_byte       = 1'b1;
          group_phase_nxt = PH_FIRST;
        end
      end
      if (have_byte && (out_count_r != {COUNT_BITS{1'b1}})) begin
        out_count_nxt = out_count_r + 1'b1;
      end
    end

    // short stream: no character seen before this final one
    bad      = corrupt_nxt || (chars_seen_r == 2'd0);
    cnt_wide = WIDE_BITS'(out_count_nxt);
    if (cnt_wide > WIDE_BITS'({REPORT_BITS{1'b1}})) begin
      cnt_rep = {REPORT_BITS{1'b1}};
    end else begin
      cnt_rep = cnt_wide[REPORT_BITS-1:0];
    end

    data_res             = '0;
    data_res.data_byte   = dec_byte;
    data_res.last_result = !final_char;

    stat_res             = '0;
    stat_res.is_status   = 1'b1;
    stat_res.status_code = bad ? STATUS_CORRUPT : STATUS_OK;
    stat_res.byte_count  = bad ? '0 : cnt_rep;
    stat_res.last_result = 1'b1;

    push = '0;
    if (take) begin
      if (have_byte) begin
        push.r0 = data_res;
        push.r1 = stat_res;
        push.num = final_char ? 2'd2 : 2'd1;
      end else if (final_char) begin
        push.r0  = stat_res;
        push.num = 2'd1;
      end
    end

    // end of stream returns to the reset state
    if (take && final_char) begin
      group_phase_nxt   = PH_FIRST;
      pending_first_nxt = '0;
      prev_sextet_nxt   = '0;
      stopped_nxt       = 1'b0;
      corrupt_nxt       = 1'b0;
      out_count_nxt     = '0;
      chars_seen_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_phase_r   <= PH_FIRST;
      pending_first_r <= '0;
      prev_sextet_r   <= '0;
      stopped_r       <= 1'b0;
      corrupt_r       <= 1'b0;
      out_count_r     <= '0;
      chars_seen_r    <= '0;
    end else begin
      group_phase_r   <= group_phase_nxt;
      pending_first_r <= pending_first_nxt;
      prev_sextet_r   <= prev_sextet_nxt;
      stopped_r       <= stopped_nxt;
      corrupt_r       <= corrupt_nxt;
      out_count_r     <= out_count_nxt;
      chars_seen_r    <= chars_seen_nxt;
    end
  end

endmodule

// ===== src/base64url_stream_decoder_unit.sv =====
// Top level of the base64url stream decoder: stream ports and result queue.
// Uses b64sd_core for decoding and b64sd_pkg for types.
//
// Takes one character per transaction (tlast marks the last character of a
// stream) and returns decoded bytes, plus one status transaction (tuser high)
// after the last character. A character is decoded in the cycle it is
// accepted and its results are written into a four-entry result queue, so
// the input takes one character per clock while in_tready is high; the
// output drains one result per clock while out_tready is high, and the
// final character of a stream can yield two results. in_tready is high while
// the queue holds at most two results, so it never waits on the current out_tready.
module base64url_stream_decoder_unit #(
  parameter int COUNT_BITS = b64sd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,   // final_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [8] status_code, [24:9] byte_count
  output logic        out_tuser,  // is_status
  output logic        out_tlast   // last_result
);
  import b64sd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);

  b64sd_push_t       push;
  b64sd_res_t        queue_r [QDEPTH];
  logic [QPTR-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR:0]     cnt_r, cnt_nxt;
  logic              in_take;
  logic              out_take;
  b64sd_res_t        head;

  assign in_tready = (cnt_r <= (QPTR+1)'(QDEPTH - 2));
  assign in_take   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_take  = out_tvalid && out_tready;

  b64sd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .in_char   (in_tdata),
    .final_char(in_tlast),
    .push      (push)
  );

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR'(push.num);
    rd_ptr_nxt = rd_ptr_r + QPTR'(out_take);
    cnt_nxt    = cnt_r + (QPTR+1)'(push.num) - (QPTR+1)'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) queue_r[wr_ptr_r] <= push.r0;
    if (push.num == 2'd2) queue_r[wr_ptr_r + QPTR'(1)] <= push.r1;
  end

  assign head      = queue_r[rd_ptr_r];
  assign out_tdata = {7'b0, head.byte_count, head.status_code, head.data_byte};
  assign out_tuser = head.is_status;
  assign out_tlast = head.last_result;

endmodule

// ===== tb/b64sd_checker.sv =====
// Scoreboard for the base64url stream decoder: watches both stream channels,
// predicts every result from the accepted characters and compares in order.
// Depends on b64sd_pkg for the result layout and status codes.
`timescale 1ns / 100ps

module b64sd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,   // final_char
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [7:0] data_byte, [8] status_code, [24:9] byte_count
  input  logic        out_tuser,  // is_status
  input  logic        out_tlast,  // last_result
  output int          fail_count,
  output int          pending
);
  import b64sd_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEF;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  localparam logic [6:0] SEXTET_INVALID = 7'h40;

  // decoder state as the block should hold it
  logic [1:0]            phase;
  logic [7:0]            first_ch;
  logic [5:0]            prev_sextet;
  logic                  stopped;
  logic                  corrupt;
  logic [COUNT_BITS-1:0] decoded_total;
  logic [1:0]            chars_seen;

  b64sd_res_t expected_results[$];
  int         mismatches = 0;
  int         result_index = 0;

  assign fail_count = mismatches;

  initial pending = 0;

  // bit 6 set means the character is not in the url-safe alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
    logic [7:0] c;
    c = {1'b0, ch[6:0]};
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "-") return 7'd62;
    if (c == "_") return 7'd63;
    return SEXTET_INVALID;
  endfunction

  function automatic logic blank_char(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d);
  endfunction

  task automatic clear_state();
    phase         = PH_FIRST;
    first_ch      = '0;
    prev_sextet   = '0;
    stopped       = 1'b0;
    corrupt       = 1'b0;
    decoded_total = '0;
    chars_seen    = '0;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic fin);
    logic [6:0] s;
    logic [6:0] a;
    logic       got_byte;
    logic [7:0] byte_val;
    logic       bad;
    b64sd_res_t r;
    got_byte = 1'b0;
    byte_val = '0;
    if (chars_seen < 2'd2) chars_seen++;
    if (!stopped && !corrupt) begin
      if (phase == PH_FIRST) begin
        // whitespace on the final character does not stop the stream
        if (blank_char(ch)) begin
          if (!fin) stopped = 1'b1;
        end else begin
          first_ch = ch;
          phase    = PH_SECOND;
        end
      end else if (blank_char(ch)) begin
        stopped = 1'b1;
      end else begin
        s = char_to_sextet(ch);
        case (phase)
          PH_SECOND: begin
            // the first character is only judged once its partner arrives
            a = char_to_sextet(first_ch);
            if (a[6] || s[6]) begin
              corrupt = 1'b1;
            end else begin
              byte_val    = {a[5:0], s[5:4]};
              got_byte    = 1'b1;
              prev_sextet = s[5:0];
              phase       = PH_THIRD;
            end
          end
          PH_THIRD: begin
            if (s[6]) begin
              corrupt = 1'b1;
            end else begin
              byte_val    = {prev_sextet[3:0], s[5:2]};
              got_byte    = 1'b1;
              prev_sextet = s[5:0];
              phase       = PH_FOURTH;
            end
          end
          default: begin
            if (s[6]) begin
              corrupt = 1'b1;
            end else begin
              byte_val = {prev_sextet[1:0], s[5:0]};
              got_byte = 1'b1;
              phase    = PH_FIRST;
            end
          end
        endcase
      end
    end

    if (got_byte) begin
      if (decoded_total != '1) decoded_total++;
      r             = '0;
      r.data_byte   = byte_val;
      r.last_result = !fin;
      expected_results.push_back(r);
    end

    if (fin) begin
      bad           = corrupt || chars_seen < 2'd2;
      r             = '0;
      r.is_status   = 1'b1;
      r.status_code = bad ? STATUS_CORRUPT : STATUS_OK;
      if (!bad) begin
        r.byte_count = (decoded_total > 65535) ? '1 : REPORT_BITS'(decoded_total);
      end
      r.last_result = 1'b1;
      expected_results.push_back(r);
      clear_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
             result_index, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    b64sd_res_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("transaction with nothing expected", out_tdata, '0);
    end else begin
      e = expected_results.pop_front();
      if (out_tuser !== e.is_status)
        report_mismatch("is_status", 32'(out_tuser), 32'(e.is_status));
      if (out_tdata[7:0] !== e.data_byte)
        report_mismatch("data_byte", 32'(out_tdata[7:0]), 32'(e.data_byte));
      if (out_tdata[8] !== e.status_code)
        report_mismatch("status_code", 32'(out_tdata[8]), 32'(e.status_code));
      if (out_tdata[24:9] !== e.byte_count)
        report_mismatch("byte_count", 32'(out_tdata[24:9]), 32'(e.byte_count));
      if (out_tdata[31:25] !== 7'd0)
        report_mismatch("tdata padding", 32'(out_tdata[31:25]), '0);
      if (out_tlast !== e.last_result)
        report_mismatch("last_result", 32'(out_tlast), 32'(e.last_result));
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
    end else begin
      // results are registered in the queue before they reach the output, so compare first
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_char(in_tdata, in_tlast);
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_base64url_stream_decoder_unit.sv =====
// Testbench top for base64url_stream_decoder_unit: clock, reset, character
// stimulus, receiver backpressure, watchdog and verdict.
// Depends on the block's RTL and on b64sd_checker for prediction and compare.
`timescale 1ns / 100ps

module tb_base64url_stream_decoder_unit;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 920;
  localparam int NUM_DIRECTED = 25;

  typedef enum {STREAM_CLEAN, STREAM_BROKEN, STREAM_NOISE} stream_kind_t;

  // {final_char, in_char}
  localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
    {1'b1, "T"},                                            // too short
    {1'b0, "T"}, {1'b0, "W"}, {1'b0, "F"}, {1'b1, "u"},     // full group ends it
    {1'b0, "-"}, {1'b1, "_"},                               // top of alphabet
    {1'b0, 8'hc1}, {1'b0, 8'he1}, {1'b0, 8'hb0}, {1'b1, 8'h00}, // bit 7 masked, bad 4th
    {1'b0, "Z"}, {1'b0, 8'h20}, {1'b1, "Q"},                // blank second drops first
    {1'b0, 8'h00}, {1'b0, "A"}, {1'b1, "B"},                // bad first seen late
    {1'b0, "Q"}, {1'b0, "U"}, {1'b0, "J"}, {1'b0, "D"}, {1'b1, 8'hff}, // lone trailing
    {1'b0, 8'h0d}, {1'b0, "A"}, {1'b1, "B"}                 // blank at group start
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] in_char
  logic        in_tlast = 1'b0; // final_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [7:0] data_byte, [8] status_code, [24:9] byte_count
  logic        out_tuser;       // is_status
  logic        out_tlast;       // last_result

  int fail_count;
  int pending;
  int burst_left = 0;
  bit hold_start = 1'b0;
  bit hold_done  = 1'b0;

  base64url_stream_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  b64sd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] alphabet_char();
    int         idx;
    logic [7:0] c;
    idx = $urandom_range(0, 63);
    if (idx < 26)      c = 8'("A" + idx);
    else if (idx < 52) c = 8'("a" + idx - 26);
    else if (idx < 62) c = 8'("0" + idx - 52);
    else if (idx == 62) c = "-";
    else               c = "_";
    c[7] = ($urandom_range(0, 7) == 0);
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 5) == 5) return 8'h20;
    return 8'(8'h09 + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_char(input stream_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      STREAM_CLEAN:  return alphabet_char();
      STREAM_BROKEN: begin
        if (r < 10) return blank_byte();
        if (r < 22) return 8'($urandom_range(0, 255));
        return alphabet_char();
      end
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one character; called and returns at a falling edge.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver: patterns of its own, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_start && !hold_done) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (k % 3) != 2;
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int           r;
    int           len;
    int           streams;
    int           random_sent;
    bit           drained_mid;
    stream_kind_t kind;
    streams     = 0;
    random_sent = 0;
    drained_mid = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_char(DIRECTED[i][7:0], DIRECTED[i][8]);
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      r    = $urandom_range(0, 99);
      kind = (r < 78) ? STREAM_CLEAN : (r < 92) ? STREAM_BROKEN : STREAM_NOISE;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      // receiver holds off while the sender keeps pushing
      if (streams == 12) hold_start = 1'b1;
      if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(kind), i == len - 1);
        random_sent++;
      end
      streams++;
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/b64sd_pkg.sv
src/b64sd_core.sv
src/base64url_stream_decoder_unit.sv
tb/b64sd_checker.sv
tb/tb_base64url_stream_decoder_unit.sv
